// ----- design/cicr_pkg.sv -----
// ----------------------------------------------------------------------------
// cicr_pkg
// Shared types and constants of the controller input change recorder.
// ----------------------------------------------------------------------------
`default_nettype none

package cicr_pkg;

    localparam int EVENT_DEPTH_DEF = 64;
    localparam int ETIME_W         = 27;

    localparam logic [27:0] HOLD_US    = 28'd10000000;
    localparam logic [16:0] MAX_DUR_MS = 17'd80000;
    localparam logic [31:0] US_PER_MS  = 32'd1000;
    localparam logic [4:0]  MASK_MAX   = 5'd31;

    localparam logic [2:0] REG_MASK  = 3'd0;
    localparam logic [2:0] REG_SSTEP = 3'd1;
    localparam logic [2:0] REG_TSTEP = 3'd2;
    localparam logic [2:0] REG_LIMIT = 3'd3;
    localparam logic [2:0] REG_DUR   = 3'd4;

    typedef enum logic [2:0] {
        ACT_START = 3'd0,
        ACT_OBS   = 3'd1,
        ACT_TICK  = 3'd2,
        ACT_STOP  = 3'd3,
        ACT_DISC  = 3'd4,
        ACT_READ  = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_REC     = 3'd1,
        ST_FULL    = 3'd2,
        ST_TIMEOUT = 3'd3,
        ST_STOP    = 3'd4,
        ST_DISC    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_QWAIT,
        C_HOLD,
        C_FINAL,
        C_READ,
        C_DONE
    } ctl_state_t;

    typedef enum logic [2:0] {
        Q_IDLE,
        Q_LOAD,
        Q_DIV,
        Q_MUL,
        Q_WB
    } q_state_t;

    typedef struct packed {
        logic [15:0] buttons;
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] rx;
        logic [15:0] ry;
        logic [15:0] lt;
        logic [15:0] rt;
    } snap_t;

    typedef struct packed {
        logic [ETIME_W-1:0] ts;
        snap_t              snap;
    } entry_t;

    typedef struct packed {
        logic               acc;
        status_t            status;
        logic [6:0]         count;
        logic [ETIME_W-1:0] elapsed;
        entry_t             entry;
    } result_t;

endpackage

`default_nettype wire

// ----- design/cicr_in_if.sv -----
// ----------------------------------------------------------------------------
// cicr_in_if
// Input channel: one controller action per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface cicr_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [7:0]         port_slot;
    logic [31:0]        link_generation;
    logic [31:0]        time_now;
    logic [15:0]        button_bits;
    logic signed [15:0] lstick_x;
    logic signed [15:0] lstick_y;
    logic signed [15:0] rstick_x;
    logic signed [15:0] rstick_y;
    logic [15:0]        ltrig_level;
    logic [15:0]        rtrig_level;
    logic [5:0]         read_index;

    modport source (
        output valid, action, port_slot, link_generation, time_now, button_bits,
        output lstick_x, lstick_y, rstick_x, rstick_y, ltrig_level, rtrig_level,
        output read_index,
        input  ready
    );
    modport sink (
        input  valid, action, port_slot, link_generation, time_now, button_bits,
        input  lstick_x, lstick_y, rstick_x, rstick_y, ltrig_level, rtrig_level,
        input  read_index,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/cicr_out_if.sv -----
// ----------------------------------------------------------------------------
// cicr_out_if
// Result channel: one status and entry beat per action.
// ----------------------------------------------------------------------------
`default_nettype none

interface cicr_out_if;
    logic               valid;
    logic               ready;
    logic               accepted;
    logic [2:0]         run_status;
    logic [6:0]         stored_count;
    logic [26:0]        elapsed_time;
    logic [26:0]        entry_time;
    logic [15:0]        entry_buttons;
    logic signed [15:0] entry_lstick_x;
    logic signed [15:0] entry_lstick_y;
    logic signed [15:0] entry_rstick_x;
    logic signed [15:0] entry_rstick_y;
    logic [15:0]        entry_ltrig;
    logic [15:0]        entry_rtrig;

    modport source (
        output valid, accepted, run_status, stored_count, elapsed_time, entry_time,
        output entry_buttons, entry_lstick_x, entry_lstick_y, entry_rstick_x,
        output entry_rstick_y, entry_ltrig, entry_rtrig,
        input  ready
    );
    modport sink (
        input  valid, accepted, run_status, stored_count, elapsed_time, entry_time,
        input  entry_buttons, entry_lstick_x, entry_lstick_y, entry_rstick_x,
        input  entry_rstick_y, entry_ltrig, entry_rtrig,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/cicr_ram.sv -----
// ----------------------------------------------------------------------------
// cicr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cicr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

`default_nettype wire

// ----- design/cicr_quant.sv -----
// ----------------------------------------------------------------------------
// cicr_quant
// Snapshot quantizer: rounds the six analog channels to their steps through
// one shared restoring divider and one multiplier, lane by lane.
// ----------------------------------------------------------------------------
`default_nettype none

module cicr_quant (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [4:0]      mask,
    input  wire logic [14:0]     sstep,
    input  wire logic [15:0]     tstep,
    input  wire cicr_pkg::snap_t sample,
    output logic                 done,
    output cicr_pkg::snap_t      result
);
    import cicr_pkg::*;

    q_state_t    qs_reg, qs_next;
    logic [2:0]  lane_reg;
    snap_t       smp_reg;
    logic [15:0] val_reg [0:5];
    logic [16:0] dvd_reg;
    logic [15:0] rem_reg;
    logic [16:0] quo_reg;
    logic [4:0]  cnt_reg;
    logic [32:0] prod_reg;
    logic        done_reg;

    logic [15:0] raw;
    logic        is_axis;
    logic        en;
    logic [15:0] q;
    logic        neg;
    logic [16:0] mag;
    logic        special;
    logic [16:0] dividend;
    logic [16:0] shifted;
    logic        ge;
    logic [16:0] diff;
    logic [32:0] lim;
    logic [15:0] r16;
    logic [15:0] rounded;
    logic        last_lane;

    always_comb
    begin
        case (lane_reg)
            3'd0:    raw = smp_reg.lx;
            3'd1:    raw = smp_reg.ly;
            3'd2:    raw = smp_reg.rx;
            3'd3:    raw = smp_reg.ry;
            3'd4:    raw = smp_reg.lt;
            default: raw = smp_reg.rt;
        endcase
        case (lane_reg)
            3'd0, 3'd1: en = mask[1];
            3'd2, 3'd3: en = mask[2];
            3'd4:       en = mask[3];
            default:    en = mask[4];
        endcase
        is_axis  = (lane_reg < 3'd4);
        q        = is_axis ? {1'b0, sstep} : tstep;
        neg      = is_axis & raw[15];
        mag      = neg ? (17'd0 - {1'b1, raw}) : {1'b0, raw};
        // full-scale values pass through untouched
        special  = is_axis ? (raw == 16'h8000 || mag == 17'd32767) : (raw == 16'hFFFF);
        dividend = mag + {2'b0, q[15:1]};
        shifted  = {rem_reg, dvd_reg[16]};
        ge       = (shifted >= {1'b0, q});
        diff     = shifted - {1'b0, q};
        lim      = is_axis ? 33'd32767 : 33'd65535;
        r16      = (prod_reg > lim) ? lim[15:0] : prod_reg[15:0];
        rounded  = neg ? (16'd0 - r16) : r16;
        last_lane = (lane_reg == 3'd5);
    end

    always_comb
    begin
        qs_next = qs_reg;
        unique case (qs_reg)
            Q_IDLE:
            begin
                if (start)
                begin
                    qs_next = Q_LOAD;
                end
            end
            Q_LOAD:
            begin
                if (!en || special)
                begin
                    qs_next = last_lane ? Q_IDLE : Q_LOAD;
                end
                else
                begin
                    qs_next = Q_DIV;
                end
            end
            Q_DIV:
            begin
                if (cnt_reg == 5'd16)
                begin
                    qs_next = Q_MUL;
                end
            end
            Q_MUL:
            begin
                qs_next = Q_WB;
            end
            Q_WB:
            begin
                qs_next = last_lane ? Q_IDLE : Q_LOAD;
            end
            default:
            begin
                qs_next = Q_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qs_reg   <= Q_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            qs_reg   <= qs_next;
            done_reg <= last_lane && ((qs_reg == Q_WB) ||
                        (qs_reg == Q_LOAD && (!en || special)));
        end
    end

    always_ff @(posedge clk)
    begin
        case (qs_reg)
            Q_IDLE:
            begin
                if (start)
                begin
                    smp_reg  <= sample;
                    lane_reg <= 3'd0;
                end
            end
            Q_LOAD:
            begin
                if (!en || special)
                begin
                    val_reg[lane_reg] <= en ? raw : 16'd0;
                    lane_reg          <= lane_reg + 3'd1;
                end
                else
                begin
                    dvd_reg <= dividend;
                    rem_reg <= 16'd0;
                    quo_reg <= 17'd0;
                    cnt_reg <= 5'd0;
                end
            end
            Q_DIV:
            begin
                rem_reg <= ge ? diff[15:0] : shifted[15:0];
                quo_reg <= {quo_reg[15:0], ge};
                dvd_reg <= {dvd_reg[15:0], 1'b0};
                cnt_reg <= cnt_reg + 5'd1;
            end
            Q_MUL:
            begin
                prod_reg <= quo_reg * q;
            end
            Q_WB:
            begin
                val_reg[lane_reg] <= rounded;
                lane_reg          <= lane_reg + 3'd1;
            end
            default:
            begin
            end
        endcase
    end

    assign done           = done_reg;
    assign result.buttons = mask[0] ? smp_reg.buttons : 16'd0;
    assign result.lx      = val_reg[0];
    assign result.ly      = val_reg[1];
    assign result.rx      = val_reg[2];
    assign result.ry      = val_reg[3];
    assign result.lt      = val_reg[4];
    assign result.rt      = val_reg[5];
endmodule

`default_nettype wire

// ----- design/controller_input_change_recorder.sv -----
// Flow: start and same-generation observe wait for the quantizer, where each
//   enabled, non-full-scale lane passes LOAD, a 17-step divider, MUL and WB.
// Observe, tick, stop, disconnect: HOLD appends one hold event per cycle, then FINAL.
// Read: through the event RAM's registered port; ignored or rejected items go
//   straight to DONE. One item at a time.
// Reset: run idle, count zero, registers at defaults; event RAM is not cleared.
// ----------------------------------------------------------------------------
// controller_input_change_recorder
// Records one controller as timestamped change events in an event RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module controller_input_change_recorder #(
    parameter int EVENT_DEPTH = cicr_pkg::EVENT_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    cicr_in_if.sink          in_ch,
    cicr_out_if.source       out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import cicr_pkg::*;

    localparam int AW = $clog2(EVENT_DEPTH);
    localparam int CW = $clog2(EVENT_DEPTH + 1);
    localparam int EW = $bits(entry_t);

    // configuration
    logic [4:0]  cfg_mask_reg;
    logic [14:0] cfg_sstep_reg;
    logic [15:0] cfg_tstep_reg;
    logic [6:0]  cfg_limit_reg;
    logic [16:0] cfg_dur_reg;
    logic        cfg_wr;

    // per-run state
    logic [4:0]         lat_mask_reg;
    logic [14:0]        lat_sstep_reg;
    logic [15:0]        lat_tstep_reg;
    logic [6:0]         lat_limit_reg;
    logic [ETIME_W-1:0] lat_dur_reg;
    status_t            status_reg;
    logic [1:0]         bound_slot_reg;
    logic [31:0]        bound_gen_reg;
    logic [31:0]        start_stamp_reg;
    logic [ETIME_W-1:0] end_off_reg;
    logic [CW-1:0]      count_reg;
    logic [ETIME_W-1:0] last_time_reg;
    snap_t              last_snap_reg;

    // current item
    ctl_state_t         state_reg, state_next;
    action_t            act_reg;
    logic               gen_eq_reg;
    logic               ending_reg;
    logic               tout_reg;
    logic [ETIME_W-1:0] target_reg;
    logic [31:0]        elapsed_reg;
    logic               acc_reg;
    entry_t             rd_ent_reg;

    // result beat
    logic    out_valid_reg;
    result_t res_reg;

    logic               in_fire;
    action_t            in_act;
    logic               start_ok;
    logic               slot_match;
    logic               gen_eq;
    logic               rd_ok;
    logic [31:0]        in_elapsed;
    logic               in_tout;
    logic [AW+5:0]      ridx_x;
    logic               q_start;
    logic               q_done;
    snap_t              in_snap;
    snap_t              q_snap;
    logic [27:0]        bnd;
    logic               hold_stop;
    logic               full;
    logic               obs_new;
    logic               obs_same_t;
    logic [CW-1:0]      cnt_m1;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    entry_t             ram_wdata;
    logic [EW-1:0]      ram_rdata;
    logic [CW+6:0]      cnt_x;
    logic [ETIME_W-1:0] out_elapsed;
    logic               slot_free;

    // ------------------------------------------------------------------ APB
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        unique case (paddr[4:2])
            REG_MASK:  prdata = {27'd0, cfg_mask_reg};
            REG_SSTEP: prdata = {17'd0, cfg_sstep_reg};
            REG_TSTEP: prdata = {16'd0, cfg_tstep_reg};
            REG_LIMIT: prdata = {25'd0, cfg_limit_reg};
            REG_DUR:   prdata = {15'd0, cfg_dur_reg};
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_mask_reg  <= MASK_MAX;
            cfg_sstep_reg <= 15'd1;
            cfg_tstep_reg <= 16'd1;
            cfg_limit_reg <= 7'd64;
            cfg_dur_reg   <= MAX_DUR_MS;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_MASK:  cfg_mask_reg  <= pwdata[4:0];
                REG_SSTEP: cfg_sstep_reg <= pwdata[14:0];
                REG_TSTEP: cfg_tstep_reg <= pwdata[15:0];
                REG_LIMIT: cfg_limit_reg <= pwdata[6:0];
                REG_DUR:   cfg_dur_reg   <= pwdata[16:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------- item decode
    assign in_ch.ready = (state_reg == C_IDLE);
    assign in_fire     = in_ch.valid & in_ch.ready;
    assign in_act      = action_t'(in_ch.action);

    assign in_snap.buttons = in_ch.button_bits;
    assign in_snap.lx      = in_ch.lstick_x;
    assign in_snap.ly      = in_ch.lstick_y;
    assign in_snap.rx      = in_ch.rstick_x;
    assign in_snap.ry      = in_ch.rstick_y;
    assign in_snap.lt      = in_ch.ltrig_level;
    assign in_snap.rt      = in_ch.rtrig_level;

    always_comb
    begin
        slot_free  = (status_reg != ST_REC);
        start_ok   = slot_free && (in_ch.port_slot < 8'd4) && (cfg_mask_reg != 5'd0)
                     && (cfg_sstep_reg != 15'd0) && (cfg_tstep_reg != 16'd0)
                     && (cfg_limit_reg != 7'd0)
                     && (32'(cfg_limit_reg) <= 32'(EVENT_DEPTH))
                     && (cfg_dur_reg != 17'd0) && (cfg_dur_reg <= MAX_DUR_MS);
        slot_match = (status_reg == ST_REC) && (in_ch.port_slot == {6'd0, bound_slot_reg});
        gen_eq     = (in_ch.link_generation == bound_gen_reg);
        rd_ok      = (32'(in_ch.read_index) < 32'(count_reg));
        in_elapsed = in_ch.time_now - start_stamp_reg;
        in_tout    = (in_elapsed >= {5'd0, lat_dur_reg});
        ridx_x     = {{AW{1'b0}}, in_ch.read_index};
        q_start    = in_fire && (((in_act == ACT_START) && start_ok) ||
                     ((in_act == ACT_OBS) && slot_match && gen_eq));
    end

    // ---------------------------------------------------------- datapath
    always_comb
    begin
        bnd        = {1'b0, last_time_reg} + HOLD_US;
        hold_stop  = (bnd > {1'b0, target_reg}) ||
                     ((bnd == {1'b0, target_reg}) && (ending_reg || tout_reg));
        full       = (32'(count_reg) >= 32'(lat_limit_reg));
        cnt_m1     = count_reg - 1'b1;
        obs_new    = (q_snap != last_snap_reg);
        obs_same_t = (elapsed_reg == {5'd0, last_time_reg});

        ram_we    = 1'b0;
        ram_waddr = count_reg[AW-1:0];
        ram_wdata = {last_time_reg, last_snap_reg};
        if (state_reg == C_HOLD && status_reg == ST_REC && !hold_stop && !full)
        begin
            ram_we    = 1'b1;
            ram_wdata = {bnd[ETIME_W-1:0], last_snap_reg};
        end
        else if (state_reg == C_FINAL)
        begin
            if (act_reg == ACT_START)
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = {{ETIME_W{1'b0}}, q_snap};
            end
            else if (act_reg == ACT_OBS && gen_eq_reg && status_reg == ST_REC && obs_new)
            begin
                ram_wdata = {elapsed_reg[ETIME_W-1:0], q_snap};
                if (obs_same_t)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_m1[AW-1:0];
                end
                else if (!full)
                begin
                    ram_we = 1'b1;
                end
            end
        end
    end

    cicr_quant u_quant (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (q_start),
        .mask   (lat_mask_reg),
        .sstep  (lat_sstep_reg),
        .tstep  (lat_tstep_reg),
        .sample (in_snap),
        .done   (q_done),
        .result (q_snap)
    );

    cicr_ram #(
        .WIDTH (EW),
        .DEPTH (EVENT_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (in_fire && in_act == ACT_READ),
        .rd_addr (ridx_x[AW-1:0]),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------ control FSM
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_act)
                        ACT_START: state_next = start_ok ? C_QWAIT : C_DONE;
                        ACT_OBS:
                        begin
                            if (!slot_match)
                            begin
                                state_next = C_DONE;
                            end
                            else
                            begin
                                state_next = gen_eq ? C_QWAIT : C_HOLD;
                            end
                        end
                        ACT_TICK, ACT_STOP: state_next = C_HOLD;
                        ACT_DISC:  state_next = (slot_match && gen_eq) ? C_HOLD : C_DONE;
                        ACT_READ:  state_next = rd_ok ? C_READ : C_DONE;
                        default:   state_next = C_DONE;
                    endcase
                end
            end
            C_QWAIT:
            begin
                if (q_done)
                begin
                    state_next = (act_reg == ACT_START) ? C_FINAL : C_HOLD;
                end
            end
            C_HOLD:
            begin
                if (status_reg != ST_REC || hold_stop || full)
                begin
                    state_next = C_FINAL;
                end
            end
            C_FINAL:
            begin
                state_next = C_DONE;
            end
            C_READ:
            begin
                state_next = C_DONE;
            end
            C_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    assign cnt_x       = {7'd0, count_reg};
    assign out_elapsed = (status_reg == ST_IDLE) ? '0 :
                         (status_reg != ST_REC) ? end_off_reg :
                         (elapsed_reg > {5'd0, lat_dur_reg}) ? lat_dur_reg :
                         elapsed_reg[ETIME_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= C_IDLE;
            status_reg      <= ST_IDLE;
            count_reg       <= '0;
            bound_slot_reg  <= 2'd0;
            bound_gen_reg   <= 32'd0;
            start_stamp_reg <= 32'd0;
            end_off_reg     <= '0;
            lat_mask_reg    <= MASK_MAX;
            lat_sstep_reg   <= 15'd1;
            lat_tstep_reg   <= 16'd1;
            lat_limit_reg   <= 7'd64;
            lat_dur_reg     <= ETIME_W'(32'(MAX_DUR_MS) * US_PER_MS);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // a new beat may load in the same cycle the old one is taken
            if (state_reg == C_DONE && (!out_valid_reg || out_ch.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                C_IDLE:
                begin
                    if (in_fire && in_act == ACT_START && start_ok)
                    begin
                        lat_mask_reg    <= cfg_mask_reg;
                        lat_sstep_reg   <= cfg_sstep_reg;
                        lat_tstep_reg   <= cfg_tstep_reg;
                        lat_limit_reg   <= cfg_limit_reg;
                        lat_dur_reg     <= ETIME_W'(32'(cfg_dur_reg) * US_PER_MS);
                        bound_slot_reg  <= in_ch.port_slot[1:0];
                        bound_gen_reg   <= in_ch.link_generation;
                        start_stamp_reg <= in_ch.time_now;
                        end_off_reg     <= '0;
                        status_reg      <= ST_REC;
                    end
                end
                C_HOLD:
                begin
                    if (status_reg == ST_REC)
                    begin
                        if (hold_stop)
                        begin
                            if (tout_reg)
                            begin
                                status_reg  <= ST_TIMEOUT;
                                end_off_reg <= lat_dur_reg;
                            end
                        end
                        else if (full)
                        begin
                            status_reg  <= ST_FULL;
                            end_off_reg <= bnd[ETIME_W-1:0];
                        end
                        else
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                C_FINAL:
                begin
                    if (act_reg == ACT_START)
                    begin
                        count_reg <= CW'(1);
                    end
                    else if (status_reg == ST_REC)
                    begin
                        if (act_reg == ACT_STOP)
                        begin
                            status_reg  <= ST_STOP;
                            end_off_reg <= elapsed_reg[ETIME_W-1:0];
                        end
                        else if (act_reg == ACT_DISC || (act_reg == ACT_OBS && !gen_eq_reg))
                        begin
                            status_reg  <= ST_DISC;
                            end_off_reg <= elapsed_reg[ETIME_W-1:0];
                        end
                        else if (act_reg == ACT_OBS && obs_new && !obs_same_t)
                        begin
                            if (full)
                            begin
                                status_reg  <= ST_FULL;
                                end_off_reg <= elapsed_reg[ETIME_W-1:0];
                            end
                            else
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            last_time_reg <= ram_wdata.ts;
            last_snap_reg <= ram_wdata.snap;
        end
        case (state_reg)
            C_IDLE:
            begin
                if (in_fire)
                begin
                    act_reg    <= in_act;
                    gen_eq_reg <= gen_eq;
                    ending_reg <= (in_act == ACT_STOP) || (in_act == ACT_DISC) ||
                                  ((in_act == ACT_OBS) && !gen_eq);
                    tout_reg   <= in_tout;
                    target_reg <= in_tout ? lat_dur_reg : in_elapsed[ETIME_W-1:0];
                    elapsed_reg <= (in_act == ACT_START && start_ok) ? 32'd0 : in_elapsed;
                    acc_reg    <= (in_act == ACT_START) ? start_ok :
                                  (in_act == ACT_READ) ? rd_ok : 1'b0;
                    rd_ent_reg <= '0;
                end
            end
            C_READ:
            begin
                rd_ent_reg <= entry_t'(ram_rdata);
            end
            C_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    res_reg.acc     <= acc_reg;
                    res_reg.status  <= status_reg;
                    res_reg.count   <= cnt_x[6:0];
                    res_reg.elapsed <= out_elapsed;
                    res_reg.entry   <= rd_ent_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.accepted       = res_reg.acc;
    assign out_ch.run_status     = res_reg.status;
    assign out_ch.stored_count   = res_reg.count;
    assign out_ch.elapsed_time   = res_reg.elapsed;
    assign out_ch.entry_time     = res_reg.entry.ts;
    assign out_ch.entry_buttons  = res_reg.entry.snap.buttons;
    assign out_ch.entry_lstick_x = res_reg.entry.snap.lx;
    assign out_ch.entry_lstick_y = res_reg.entry.snap.ly;
    assign out_ch.entry_rstick_x = res_reg.entry.snap.rx;
    assign out_ch.entry_rstick_y = res_reg.entry.snap.ry;
    assign out_ch.entry_ltrig    = res_reg.entry.snap.lt;
    assign out_ch.entry_rtrig    = res_reg.entry.snap.rt;

    // ---------------------------------------------------------- checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(EVENT_DEPTH))
        else $error("event count above depth");

    a_rec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg == ST_REC && state_reg == C_IDLE) |-> count_reg != '0)
        else $error("recording with empty event list");

    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == C_HOLD || state_reg == C_FINAL))
        else $error("event RAM written outside hold or final step");

    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != C_IDLE)
        else $error("accepted beat produced no work");
endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the controller input change recorder: directed and
// random action beats, APB register phases, scoreboard of predicted results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import cicr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]         action;
        logic [7:0]         slot;
        logic [31:0]        gen;
        logic [31:0]        now;
        logic [15:0]        btn;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic [15:0]        lt;
        logic [15:0]        rt;
        logic [5:0]         ridx;
    } action_beat_t;

    typedef struct packed {
        logic        acc;
        logic [2:0]  status;
        logic [6:0]  count;
        logic [26:0] elapsed;
        logic [26:0] etime;
        logic [15:0] ebtn;
        logic [15:0] elx;
        logic [15:0] ely;
        logic [15:0] erx;
        logic [15:0] ery;
        logic [15:0] elt;
        logic [15:0] ert;
    } status_beat_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    cicr_in_if  in_ch ();
    cicr_out_if out_ch ();

    controller_input_change_recorder DUT (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // register file and run copy held by the predictor
    logic [31:0] cfg_mask, cfg_sstep, cfg_tstep, cfg_limit, cfg_dur;
    logic [31:0] run_mask, run_sstep, run_tstep, run_limit, run_dur;
    logic [2:0]  rec_status;
    logic [1:0]  rec_slot;
    logic [31:0] rec_gen, rec_start, rec_end, rec_count;
    logic [31:0] ev_time [64];
    logic [15:0] ev_btn [64];
    logic [63:0] ev_sticks [64];
    logic [31:0] ev_trig [64];

    action_beat_t pending_actions[$];
    status_beat_t expected_status[$];
    int errors = 0;
    int n_sent = 0, n_got = 0, n_reads_ok = 0;
    bit hold_off = 0;
    bit hold_go = 0;
    // handshakes seen at the last rising edge
    bit in_fired = 0;
    bit out_fired = 0;

    // recorder's current timebase for stimulus
    logic [31:0] t_base;
    logic [31:0] cur_gen;
    logic [1:0]  cur_slot;

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] quant_axis(logic signed [15:0] v, logic [31:0] q);
        logic [31:0] mag, r;
        if (v == -16'sd32768) return 16'h8000;
        mag = v < 0 ? 32'(-int'(v)) : 32'(int'(v));
        if (mag == 32767) return v;
        r = ((mag + q / 2) / q) * q;
        if (r > 32767) r = 32767;
        return v < 0 ? 16'(32'h10000 - r) : r[15:0];
    endfunction

    function automatic logic [15:0] quant_trig(logic [15:0] v, logic [31:0] q);
        logic [31:0] r;
        if (v == 16'hFFFF) return v;
        r = ((32'(v) + q / 2) / q) * q;
        return r > 32'hFFFF ? 16'hFFFF : r[15:0];
    endfunction

    task automatic snapshot(input action_beat_t a, output logic [15:0] b,
                            output logic [63:0] s, output logic [31:0] t);
        logic [15:0] lx, ly, rx, ry, lt, rt;
        lx = 0; ly = 0; rx = 0; ry = 0; lt = 0; rt = 0;
        b = run_mask[0] ? a.btn : 16'd0;
        if (run_mask[1]) begin
            lx = quant_axis(a.lx, run_sstep);
            ly = quant_axis(a.ly, run_sstep);
        end
        if (run_mask[2]) begin
            rx = quant_axis(a.rx, run_sstep);
            ry = quant_axis(a.ry, run_sstep);
        end
        if (run_mask[3]) lt = quant_trig(a.lt, run_tstep);
        if (run_mask[4]) rt = quant_trig(a.rt, run_tstep);
        s = {ry, rx, ly, lx};
        t = {rt, lt};
    endtask

    function automatic void end_run(logic [2:0] st, logic [31:0] at);
        rec_status = st;
        rec_end = at & 32'h7FFFFFF;
    endfunction

    function automatic bit append_event(logic [31:0] t, logic [15:0] b, logic [63:0] s,
                                        logic [31:0] tr);
        int last;
        last = (rec_count - 1) % 64;
        if (ev_time[last] == t) begin
            ev_btn[last] = b; ev_sticks[last] = s; ev_trig[last] = tr;
            return 1;
        end
        if (rec_count >= run_limit || rec_count >= 64) begin
            end_run(ST_FULL, t);
            return 0;
        end
        ev_time[rec_count] = t; ev_btn[rec_count] = b;
        ev_sticks[rec_count] = s; ev_trig[rec_count] = tr;
        rec_count++;
        return 1;
    endfunction

    function automatic void catch_up_holds(logic [31:0] now, bit ending);
        logic [31:0] el, dur, target, bnd;
        bit tout;
        int last;
        if (rec_status != ST_REC) return;
        el = now - rec_start;
        dur = run_dur * 1000;
        tout = el >= dur;
        target = tout ? dur : el;
        for (int n = 0; n < 64; n++) begin
            last = (rec_count - 1) % 64;
            bnd = ev_time[last] + 32'd10000000;
            if (bnd > target || (bnd == target && (ending || tout))) break;
            if (!append_event(bnd, ev_btn[last], ev_sticks[last], ev_trig[last])) return;
        end
        if (tout) end_run(ST_TIMEOUT, dur);
    endfunction

    task automatic predict_status(input action_beat_t a, output status_beat_t r);
        logic [15:0] b;
        logic [63:0] s;
        logic [31:0] tr, el, dur;
        int last;
        r = '0;
        case (a.action)
            ACT_START:
                if (rec_status != ST_REC && a.slot < 4 && cfg_mask != 0 && cfg_mask <= 31 &&
                    cfg_sstep != 0 && cfg_tstep != 0 && cfg_limit != 0 && cfg_limit <= 64 &&
                    cfg_dur != 0 && cfg_dur <= 80000) begin
                    run_mask = cfg_mask; run_sstep = cfg_sstep; run_tstep = cfg_tstep;
                    run_limit = cfg_limit; run_dur = cfg_dur;
                    rec_slot = a.slot[1:0]; rec_gen = a.gen; rec_start = a.now; rec_end = 0;
                    snapshot(a, b, s, tr);
                    ev_time[0] = 0; ev_btn[0] = b; ev_sticks[0] = s; ev_trig[0] = tr;
                    rec_count = 1;
                    rec_status = ST_REC;
                    r.acc = 1;
                end
            ACT_OBS:
                if (rec_status == ST_REC && a.slot == {6'd0, rec_slot}) begin
                    if (a.gen != rec_gen) begin
                        catch_up_holds(a.now, 1);
                        if (rec_status == ST_REC) end_run(ST_DISC, a.now - rec_start);
                    end else begin
                        catch_up_holds(a.now, 0);
                        if (rec_status == ST_REC) begin
                            last = (rec_count - 1) % 64;
                            snapshot(a, b, s, tr);
                            if (b != ev_btn[last] || s != ev_sticks[last] || tr != ev_trig[last])
                                void'(append_event(a.now - rec_start, b, s, tr));
                        end
                    end
                end
            ACT_TICK: catch_up_holds(a.now, 0);
            ACT_STOP: begin
                catch_up_holds(a.now, 1);
                if (rec_status == ST_REC) end_run(ST_STOP, a.now - rec_start);
            end
            ACT_DISC:
                if (rec_status == ST_REC && a.slot == {6'd0, rec_slot} && a.gen == rec_gen) begin
                    catch_up_holds(a.now, 1);
                    if (rec_status == ST_REC) end_run(ST_DISC, a.now - rec_start);
                end
            ACT_READ:
                if (a.ridx < rec_count) begin
                    r.acc = 1;
                    r.etime = ev_time[a.ridx][26:0];
                    r.ebtn = ev_btn[a.ridx];
                    {r.ery, r.erx, r.ely, r.elx} = ev_sticks[a.ridx];
                    {r.ert, r.elt} = ev_trig[a.ridx];
                end
            default: ;
        endcase
        if (rec_status == ST_IDLE) el = 0;
        else if (rec_status != ST_REC) el = rec_end;
        else begin
            el = a.now - rec_start;
            dur = run_dur * 1000;
            if (el > dur) el = dur;
        end
        r.status = rec_status;
        r.count = rec_count[6:0];
        r.elapsed = el[26:0];
    endtask

    // ---------------- driver ----------------
    int src_gap = 0;
    action_beat_t cur_beat;
    always @(negedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 0;
        end else if (in_ch.valid && !in_fired) begin
            // holding the offered beat
        end else begin
            if (in_ch.valid) src_gap = $urandom_range(0, 5) * ($urandom_range(0, 3) != 0);
            if (src_gap > 0 || pending_actions.size() == 0) begin
                if (src_gap > 0) src_gap--;
                in_ch.valid <= 0;
            end else begin
                cur_beat = pending_actions.pop_front();
                in_ch.valid <= 1;
                in_ch.action <= cur_beat.action;
                in_ch.port_slot <= cur_beat.slot;
                in_ch.link_generation <= cur_beat.gen;
                in_ch.time_now <= cur_beat.now;
                in_ch.button_bits <= cur_beat.btn;
                in_ch.lstick_x <= cur_beat.lx;
                in_ch.lstick_y <= cur_beat.ly;
                in_ch.rstick_x <= cur_beat.rx;
                in_ch.rstick_y <= cur_beat.ry;
                in_ch.ltrig_level <= cur_beat.lt;
                in_ch.rtrig_level <= cur_beat.rt;
                in_ch.read_index <= cur_beat.ridx;
                src_gap = $urandom_range(0, 5) * ($urandom_range(0, 3) != 0);
            end
        end
    end

    // accepted beat feeds the predictor at the sampling edge
    always @(posedge clk) begin
        action_beat_t a;
        status_beat_t r;
        in_fired = rst_n && in_ch.valid && in_ch.ready;
        if (in_fired) begin
            a = {in_ch.action, in_ch.port_slot, in_ch.link_generation, in_ch.time_now,
                 in_ch.button_bits, in_ch.lstick_x, in_ch.lstick_y, in_ch.rstick_x,
                 in_ch.rstick_y, in_ch.ltrig_level, in_ch.rtrig_level, in_ch.read_index};
            predict_status(a, r);
            expected_status.push_back(r);
            n_sent++;
        end
    end

    // ---------------- receiver ----------------
    int sink_gap = 0;
    always @(negedge clk) begin
        if (!rst_n) out_ch.ready <= 0;
        else if (hold_off) out_ch.ready <= 0;
        else begin
            if (out_fired)
                sink_gap = $urandom_range(0, 5) * ($urandom_range(0, 3) != 0);
            if (sink_gap > 0) begin
                sink_gap--;
                out_ch.ready <= 0;
            end else begin
                out_ch.ready <= 1;
            end
        end
    end

    // long receiver stall, counted here
    initial begin
        wait (hold_go);
        hold_off = 1;
        repeat (400) @(negedge clk);
        hold_off = 0;
    end

    // ---------------- monitor ----------------
    always @(posedge clk) begin
        status_beat_t got, exp_r;
        out_fired = rst_n && out_ch.valid && out_ch.ready;
        if (out_fired) begin
            got = {out_ch.accepted, out_ch.run_status, out_ch.stored_count, out_ch.elapsed_time,
                   out_ch.entry_time, out_ch.entry_buttons, out_ch.entry_lstick_x,
                   out_ch.entry_lstick_y, out_ch.entry_rstick_x, out_ch.entry_rstick_y,
                   out_ch.entry_ltrig, out_ch.entry_rtrig};
            n_got++;
            if (expected_status.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %p", got);
            end else begin
                exp_r = expected_status.pop_front();
                n_reads_ok += exp_r.acc;
                if (got.acc !== exp_r.acc || got.status !== exp_r.status ||
                    got.count !== exp_r.count || got.elapsed !== exp_r.elapsed ||
                    got.etime !== exp_r.etime || got.ebtn !== exp_r.ebtn ||
                    got.elx !== exp_r.elx || got.ely !== exp_r.ely ||
                    got.erx !== exp_r.erx || got.ery !== exp_r.ery ||
                    got.elt !== exp_r.elt || got.ert !== exp_r.ert) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch at beat %0d\n  exp %p\n  got %p", n_got, exp_r, got);
                end
            end
        end
    end

    // ---------------- APB ----------------
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            REG_MASK:  cfg_mask = val & 32'h1F;
            REG_SSTEP: cfg_sstep = val & 32'h7FFF;
            REG_TSTEP: cfg_tstep = val & 32'hFFFF;
            REG_LIMIT: cfg_limit = val & 32'h7F;
            REG_DUR:   cfg_dur = val & 32'h1FFFF;
            default: ;
        endcase
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic drain;
        while (pending_actions.size() != 0 || in_ch.valid || expected_status.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic action_beat_t rand_beat(logic [2:0] act);
        action_beat_t a;
        a.action = act;
        a.slot = ($urandom_range(0, 7) == 0) ? 8'($urandom) : {6'd0, cur_slot};
        a.gen = ($urandom_range(0, 15) == 0) ? $urandom : cur_gen;
        a.now = t_base;
        a.btn = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'(1 << $urandom_range(0, 15));
        a.lx = 16'($urandom); a.ly = 16'($urandom);
        a.rx = 16'($urandom); a.ry = 16'($urandom);
        a.lt = 16'($urandom); a.rt = 16'($urandom);
        a.ridx = 6'($urandom_range(0, 63));
        return a;
    endfunction

    function automatic void queue_start(logic [1:0] slot);
        action_beat_t a;
        cur_slot = slot;
        cur_gen = $urandom;
        t_base = $urandom;
        a = rand_beat(ACT_START);
        a.slot = {6'd0, slot};
        a.gen = cur_gen;
        pending_actions.push_back(a);
    endfunction

    // one session: start, a random run of mostly observes and ticks, maybe an end, reads
    function automatic void queue_session(int len, int max_step_us);
        action_beat_t a;
        int pick;
        queue_start(2'($urandom_range(0, 3)));
        for (int i = 0; i < len; i++) begin
            t_base += $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, max_step_us);
            pick = $urandom_range(0, 99);
            if (pick < 60) a = rand_beat(ACT_OBS);
            else if (pick < 75) a = rand_beat(ACT_TICK);
            else if (pick < 88) a = rand_beat(ACT_READ);
            else if (pick < 91) a = rand_beat(ACT_STOP);
            else if (pick < 94) a = rand_beat(ACT_DISC);
            else if (pick < 97) a = rand_beat(ACT_START);
            else a = rand_beat(3'($urandom_range(6, 7)));
            pending_actions.push_back(a);
        end
        for (int i = 0; i < 4; i++) pending_actions.push_back(rand_beat(ACT_READ));
    endfunction

    action_beat_t d;
    int phase;
    initial begin
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_ch.valid = 0; in_ch.action = 0; in_ch.port_slot = 0; in_ch.link_generation = 0;
        in_ch.time_now = 0; in_ch.button_bits = 0; in_ch.lstick_x = 0; in_ch.lstick_y = 0;
        in_ch.rstick_x = 0; in_ch.rstick_y = 0; in_ch.ltrig_level = 0; in_ch.rtrig_level = 0;
        in_ch.read_index = 0; out_ch.ready = 0;
        cfg_mask = 31; cfg_sstep = 1; cfg_tstep = 1; cfg_limit = 64; cfg_dur = 80000;
        run_mask = 31; run_sstep = 1; run_tstep = 1; run_limit = 64; run_dur = 80000;
        rec_status = ST_IDLE; rec_slot = 0; rec_gen = 0; rec_start = 0; rec_end = 0;
        rec_count = 0;
        for (int i = 0; i < 64; i++) begin
            ev_time[i] = 0; ev_btn[i] = 0; ev_sticks[i] = 0; ev_trig[i] = 0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: defaults, extremes, rejects, wrap of the microsecond clock
        d = rand_beat(ACT_TICK); pending_actions.push_back(d);
        d = rand_beat(ACT_READ); d.ridx = 0; pending_actions.push_back(d);
        d = rand_beat(ACT_START); d.slot = 4; pending_actions.push_back(d);
        cur_slot = 3; cur_gen = 32'hFFFFFFFF; t_base = 32'hFFFF0000;
        d = rand_beat(ACT_START); d.slot = 3; d.gen = cur_gen; d.btn = 16'hFFFF;
        d.lx = -16'sd32768; d.ly = 16'sd32767; d.rx = -16'sd32767; d.ry = 0;
        d.lt = 16'hFFFF; d.rt = 0;
        pending_actions.push_back(d);
        d.action = ACT_START; pending_actions.push_back(d);          // reject: recording
        d.action = ACT_OBS; d.now = t_base; d.btn = 0;                  // same offset replace
        pending_actions.push_back(d);
        d.now = t_base + 32'h20000; d.lx = 16'sd12345; pending_actions.push_back(d);
        d.action = ACT_TICK; d.now = t_base + 32'd25000000; pending_actions.push_back(d);
        d.action = ACT_DISC; d.gen = 5; pending_actions.push_back(d); // wrong gen: ignored
        d.action = ACT_OBS; d.slot = 1; pending_actions.push_back(d); // other slot
        d.action = 3'd6; pending_actions.push_back(d);
        d.action = 3'd7; pending_actions.push_back(d);
        d.action = ACT_OBS; d.slot = 3; d.gen = 7; d.now = t_base + 32'd30000000;
        pending_actions.push_back(d);                                 // gen change: disconnect
        for (int i = 0; i < 5; i++) begin
            d = rand_beat(ACT_READ); d.ridx = 6'(i); pending_actions.push_back(d);
        end
        d.ridx = 63; pending_actions.push_back(d);
        d.action = ACT_STOP; pending_actions.push_back(d);
        drain();

        // zero or out-of-range register values make start reject
        reg_write(REG_MASK, 0);
        queue_start(0); drain();
        reg_write(REG_MASK, 31); reg_write(REG_SSTEP, 0);
        queue_start(0); drain();
        reg_write(REG_SSTEP, 1); reg_write(REG_TSTEP, 0);
        queue_start(0); drain();
        reg_write(REG_TSTEP, 1); reg_write(REG_LIMIT, 65);
        queue_start(0); drain();
        reg_write(REG_LIMIT, 64); reg_write(REG_DUR, 80001);
        queue_start(0); drain();
        reg_write(REG_DUR, 80000);

        // long hold: a start then many observes pile up behind a stalled receiver
        hold_go = 1;
        queue_session(20, 2000000);
        wait (hold_off);
        wait (!hold_off);
        drain();

        // random phases over register settings
        for (phase = 0; phase < 10; phase++) begin
            case (phase % 4)
                0: begin
                    reg_write(REG_MASK, 31); reg_write(REG_SSTEP, 1);
                    reg_write(REG_TSTEP, 1); reg_write(REG_LIMIT, 64);
                    reg_write(REG_DUR, 80000);
                end
                1: begin
                    reg_write(REG_MASK, 1); reg_write(REG_SSTEP, 32767);
                    reg_write(REG_TSTEP, 65535); reg_write(REG_LIMIT, 1);
                    reg_write(REG_DUR, 1);
                end
                default: begin
                    reg_write(REG_MASK, $urandom_range(1, 31));
                    reg_write(REG_SSTEP, $urandom_range(1, 32767) >> $urandom_range(0, 14));
                    reg_write(REG_TSTEP, $urandom_range(1, 65535) >> $urandom_range(0, 15));
                    reg_write(REG_LIMIT, $urandom_range(2, 64));
                    reg_write(REG_DUR, $urandom_range(1, 80000));
                end
            endcase
            for (int s = 0; s < 2; s++)
                queue_session($urandom_range(10, 30),
                              $urandom_range(0, 1) ? 3000000 : 30000000);
            drain();
        end

        $display("ran %0d action beats, %0d results, %0d accepted starts or reads",
                 n_sent, n_got, n_reads_ok);
        if (errors == 0 && expected_status.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
design/cicr_pkg.sv
design/cicr_in_if.sv
design/cicr_out_if.sv
design/cicr_ram.sv
design/cicr_quant.sv
design/controller_input_change_recorder.sv
dv/tb.sv
